### hw/rtl/hvt_pkg.sv
// Shared constants and types for the homogeneous vertex transform.
`timescale 1ns / 1ps
package hvt_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_W         = 68;   // exact column sum width
  localparam int QB            = 33;   // quotient bits resolved by the divider
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = 4;

  typedef logic signed [31:0]      coord_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // one lane of the bit-serial divider pipeline
  typedef struct packed {
    logic [ACC_W-1:0] rem;
    logic [QB-1:0]    num;
    logic [QB-1:0]    quo;
    logic             neg;
    logic             ovf;
  } div_lane_t;
endpackage

### hw/rtl/hvt_mac.sv
// Multiply stage and column sum stage of the 4x4 transform.
`timescale 1ns / 1ps
module hvt_mac #(
  parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en_mul,
  input  logic                en_sum,
  input  hvt_pkg::coord_t     pt [3],
  input  hvt_pkg::coord_t     mat [16],
  output hvt_pkg::acc_t       acc [4]
);
  import hvt_pkg::*;

  logic signed [63:0] prod_r [3][4];
  acc_t               trans_r [4];
  acc_t               acc_r [4];

  // twelve 32x32 products plus the translation row
  always_ff @(posedge clk) begin
    if (en_mul) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_r[r][c] <= pt[r] * mat[r*4+c];
        end
        trans_r[c] <= ACC_W'(mat[12+c]) <<< FRAC_BITS;
      end
    end
  end

  // exact column sums
  always_ff @(posedge clk) begin
    if (en_sum) begin
      for (int c = 0; c < 4; c++) begin
        acc_r[c] <= trans_r[c] + ACC_W'(prod_r[0][c]) + ACC_W'(prod_r[1][c])
                    + ACC_W'(prod_r[2][c]);
      end
    end
  end

  assign acc = acc_r;
endmodule

### hw/rtl/hvt_div_stage.sv
// One restoring-division step: resolves one quotient bit for one lane.
`timescale 1ns / 1ps
module hvt_div_stage (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hvt_pkg::ACC_W-1:0]  den,
  input  hvt_pkg::div_lane_t         lane_in,
  output hvt_pkg::div_lane_t         lane_out
);
  import hvt_pkg::*;

  logic [ACC_W:0] trial;
  logic           take;
  div_lane_t      lane_nxt;
  div_lane_t      lane_r;

  // shift in the next numerator bit and try to subtract
  always_comb begin
    trial        = {lane_in.rem, lane_in.num[QB-1]};
    take         = trial >= {1'b0, den};
    lane_nxt     = lane_in;
    lane_nxt.rem = take ? ACC_W'(trial - {1'b0, den}) : ACC_W'(trial);
    lane_nxt.num = {lane_in.num[QB-2:0], 1'b0};
    lane_nxt.quo = {lane_in.quo[QB-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;
endmodule

### hw/rtl/homogeneous_vertex_transform_core.sv
// Top level: 4x4 homogeneous point transform with perspective divide.
// A point is taken in every cycle that in_stall is low, and its result passes through
// one multiply stage, one sum stage, one stage that takes magnitudes, one
// stage that checks for quotient overflow and sets up the divider, and 33
// one-bit divider stages, the last of which drives the outputs through the
// sign, saturation and zero-w logic. Throughput is one point per clock; a
// stall on the output backs up only as far as the pipeline is full, so
// bubbles are squeezed out first.
// Matrix registers (cfg_index 0..7) hold two Q entries each, the lower
// entry in bits 31:0; writes to other indexes are dropped. They should be
// written while no point is in flight.
`timescale 1ns / 1ps
module homogeneous_vertex_transform_core #(
  parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [31:0]                in_point_x,
  input  logic signed [31:0]                in_point_y,
  input  logic signed [31:0]                in_point_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                out_x,
  output logic signed [31:0]                out_y,
  output logic signed [31:0]                out_z,
  output logic                              out_w_was_zero,
  output logic                              out_saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hvt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                       cfg_data
);
  import hvt_pkg::*;

  localparam int NST  = QB + 4;        // mul, sum, abs, ovf, 33 div
  localparam int S_AB = 2;
  localparam int S_OV = 3;
  localparam int S_D0 = 3;
  localparam int S_OUT = NST - 1;
  localparam int NUM_W = ACC_W + FRAC_BITS;
  localparam int CMP_W = ACC_W + QB + FRAC_BITS;
  localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ONE_HI = ONE_LO << 32;

  // matrix registers
  logic [63:0] mat_r [NUM_REGS];
  coord_t      mat [16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (i == 0 || i == 5) mat_r[i] <= ONE_LO;
        else if (i == 2 || i == 7) mat_r[i] <= ONE_HI;
        else mat_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      mat_r[cfg_index[2:0]] <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      mat[k] = (k % 2 == 1) ? coord_t'(mat_r[k/2][63:32]) : coord_t'(mat_r[k/2][31:0]);
    end
  end

  // valid bits and per-stage advance enables
  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  assign en[NST] = !out_stall;
  generate
    for (genvar i = 0; i < NST; i++) begin : g_en
      assign en[i] = !v_r[i] || en[i+1];
    end
  endgenerate
  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // multiply and sum
  coord_t pt [3];
  acc_t   acc [4];
  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  hvt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk    (clk),
    .en_mul (en[0]),
    .en_sum (en[1]),
    .pt     (pt),
    .mat    (mat),
    .acc    (acc)
  );

  // magnitudes and signs
  logic [ACC_W-1:0] mag_r [3];
  logic [2:0]       neg_r;
  logic [ACC_W-1:0] wmag_r;
  logic             wz_r;

  always_ff @(posedge clk) begin
    if (en[S_AB]) begin
      for (int c = 0; c < 3; c++) begin
        mag_r[c] <= acc[c][ACC_W-1] ? ACC_W'(-acc[c]) : ACC_W'(acc[c]);
        neg_r[c] <= acc[c][ACC_W-1] ^ acc[3][ACC_W-1];
      end
      wmag_r <= acc[3][ACC_W-1] ? ACC_W'(-acc[3]) : ACC_W'(acc[3]);
      wz_r   <= acc[3] == '0;
    end
  end

  // overflow check and divider setup
  div_lane_t        lane [S_D0:S_OUT][3];
  logic [ACC_W-1:0] den_r [S_D0:S_OUT];
  logic             wzp_r [S_D0:S_OUT];
  logic [NUM_W-1:0] numer [3];

  always_comb begin
    for (int c = 0; c < 3; c++) numer[c] = NUM_W'(mag_r[c]) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en[S_OV]) begin
      for (int c = 0; c < 3; c++) begin
        lane[S_D0][c].rem <= ACC_W'(numer[c] >> QB);
        lane[S_D0][c].num <= numer[c][QB-1:0];
        lane[S_D0][c].quo <= '0;
        lane[S_D0][c].neg <= neg_r[c];
        lane[S_D0][c].ovf <= CMP_W'(numer[c]) >= (CMP_W'(wmag_r) << QB);
      end
      den_r[S_D0] <= wmag_r;
      wzp_r[S_D0] <= wz_r;
    end
  end

  // one quotient bit per stage
  generate
    for (genvar s = S_D0; s < S_OUT; s++) begin : g_div
      for (genvar c = 0; c < 3; c++) begin : g_lane
        hvt_div_stage u_stage (
          .clk      (clk),
          .en       (en[s+1]),
          .den      (den_r[s]),
          .lane_in  (lane[s][c]),
          .lane_out (lane[s+1][c])
        );
      end
      always_ff @(posedge clk) begin
        if (en[s+1]) begin
          den_r[s+1] <= den_r[s];
          wzp_r[s+1] <= wzp_r[s];
        end
      end
    end
  endgenerate

  // sign, saturation and zero-w handling on the final lane words
  coord_t     res [3];
  logic [2:0] sat;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (lane[S_OUT][c].neg) begin
        sat[c] = lane[S_OUT][c].ovf || lane[S_OUT][c].quo > QB'(33'h080000000);
        res[c] = sat[c] ? coord_t'(32'h80000000)
                        : coord_t'(32'(-lane[S_OUT][c].quo));
      end else begin
        sat[c] = lane[S_OUT][c].ovf || lane[S_OUT][c].quo > QB'(33'h07FFFFFFF);
        res[c] = sat[c] ? coord_t'(32'h7FFFFFFF) : coord_t'(lane[S_OUT][c].quo[31:0]);
      end
      if (wzp_r[S_OUT]) begin
        sat[c] = 1'b0;
        res[c] = '0;
      end
    end
  end

  assign out_valid      = v_r[S_OUT];
  assign out_x          = res[0];
  assign out_y          = res[1];
  assign out_z          = res[2];
  assign out_w_was_zero = wzp_r[S_OUT];
  assign out_saturated  = |sat;

  // checks
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r) && out_stall)
    else $error("input stalled while pipeline has a bubble");

  a_wzero_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_was_zero |-> out_x == 0 && out_y == 0 && out_z == 0)
    else $error("zero w word carries nonzero coordinates");

  a_wzero_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_was_zero |-> !out_saturated)
    else $error("zero w word flagged as saturated");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_x == 32'sh7FFFFFFF || out_x == -32'sh80000000 ||
      out_y == 32'sh7FFFFFFF || out_y == -32'sh80000000 ||
      out_z == 32'sh7FFFFFFF || out_z == -32'sh80000000)
    else $error("saturated word without a clipped coordinate");
endmodule

### verif/homogeneous_vertex_transform_core_tb.sv
// Testbench for the homogeneous vertex transform core: predicts and checks every result.
`timescale 1ns / 1ps
module homogeneous_vertex_transform_core_tb;
  import hvt_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = 38;
  localparam logic [CFG_IDX_W-1:0] IDX_M01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_M23 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_M45 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_M67 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_M89 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_MAB = 4'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_MCD = 4'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_MEF = 4'd7;
  localparam logic [CFG_IDX_W-1:0] IDX_BAD = 4'd9;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               wz;
    logic               sat;
  } vertex_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic out_w_was_zero, out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] mat_shadow [NUM_REGS];
  vertex_res_t expected_q[$];
  int errors = 0;
  bit hold_out = 1'b0;
  int hold_cycles = 0;

  homogeneous_vertex_transform_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_w_was_zero(out_w_was_zero), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // matrix entry k as a signed value
  function automatic logic signed [31:0] mat_entry(int k);
    logic [63:0] r;
    r = mat_shadow[k/2];
    return (k % 2) ? r[63:32] : r[31:0];
  endfunction

  // divide one column sum by w, truncating, and clip to 32 bits
  function automatic logic [31:0] persp_divide(logic signed [127:0] acc,
                                               logic signed [127:0] accw,
                                               ref logic sat);
    logic [127:0] a, w, q;
    logic neg;
    neg = (acc < 0) != (accw < 0);
    a = (acc < 0) ? -acc : acc;
    w = (accw < 0) ? -accw : accw;
    q = (a << FB) / w;
    if (neg) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return -q[31:0];
    end
    if (q > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic vertex_res_t transform_point(logic signed [31:0] px,
                                                  logic signed [31:0] py,
                                                  logic signed [31:0] pz);
    logic signed [127:0] acc [4];
    logic signed [127:0] p [3];
    vertex_res_t r;
    logic sat;
    p[0] = px; p[1] = py; p[2] = pz;
    for (int c = 0; c < 4; c++) begin
      acc[c] = 128'(mat_entry(12 + c)) <<< FB;
      for (int k = 0; k < 3; k++)
        acc[c] = acc[c] + p[k] * 128'(mat_entry(k*4 + c));
    end
    r = '0;
    if (acc[3] == 0) begin
      r.wz = 1'b1;
      return r;
    end
    sat = 1'b0;
    r.x = persp_divide(acc[0], acc[3], sat);
    r.y = persp_divide(acc[1], acc[3], sat);
    r.z = persp_divide(acc[2], acc[3], sat);
    r.sat = sat;
    return r;
  endfunction

  // send one point word, with a random gap in front if gaps is set; valid stays up afterwards
  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px; in_point_y <= py; in_point_z <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(transform_point(px, py, pz));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_REGS) mat_shadow[idx[2:0]] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_matrix(logic [31:0] m [16]);
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(CFG_IDX_W'(i), {m[2*i+1], m[2*i]});
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 2000 << FB)) - (1000 << FB));
    endcase
  endfunction

  // receiver: random stall, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_out) begin
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end else begin
      hold_cycles <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      out_stall <= ($urandom_range(0, 3) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
    end
  end

  // result checker
  always @(posedge clk) begin
    vertex_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h", $time, out_x, out_y, out_z);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_x !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, out_x);
          errors++;
        end
        if (out_y !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, out_y);
          errors++;
        end
        if (out_z !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.z, out_z);
          errors++;
        end
        if (out_w_was_zero !== e.wz) begin
          $display("%0t: w_was_zero expected %b actual %b", $time, e.wz, out_w_was_zero);
          errors++;
        end
        if (out_saturated !== e.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, e.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  // identity matrix from reset, edge points
  task automatic test_reset_identity();
    send_point(32'sh0, 32'sh0, 32'sh0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA);
    drain();
  endtask

  // zero w, both overflow directions, dropped write index
  task automatic test_special_cases();
    logic [31:0] m [16];
    foreach (m[i]) m[i] = '0;
    m[0] = ONE; m[5] = ONE; m[10] = ONE;
    m[15] = '0;
    m[3] = ONE;
    load_matrix(m);
    send_point(ONE, 32'sh0, 32'sh0);
    send_point(32'sh0, 32'sh0, 32'sh0);
    send_point(32'h8000_0000, ONE, ONE);
    drain();
    // tiny w drives quotients past the range both ways
    m[3] = '0; m[15] = 32'h0000_0001;
    load_matrix(m);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, ONE);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'sh0);
    drain();
    // negative w and extreme entries
    m[15] = 32'h8000_0000; m[0] = 32'h7FFF_FFFF; m[5] = 32'h8000_0000;
    m[12] = 32'h7FFF_FFFF; m[13] = 32'h8000_0000; m[14] = 32'hFFFF_FFFF;
    load_matrix(m);
    write_reg(IDX_BAD, 64'hDEAD_BEEF_DEAD_BEEF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(ONE, 32'hFFFF_0000, 32'h0000_8000);
    drain();
    write_reg(IDX_M01, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(IDX_M23, 64'h0);
    write_reg(IDX_M45, 64'h0000_0000_0000_0000);
    write_reg(IDX_M67, 64'hFFFF_FFFF_0000_0000);
    write_reg(IDX_M89, 64'h8000_0000_7FFF_FFFF);
    write_reg(IDX_MAB, 64'h7FFF_FFFF_8000_0000);
    write_reg(IDX_MCD, 64'h0001_0000_FFFF_0000);
    write_reg(IDX_MEF, 64'hFFFF_FFFF_0001_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF);
    drain();
  endtask

  // random matrices and random points, in several phases
  task automatic test_random_points(int phases, int per_phase);
    logic [31:0] m [16];
    for (int ph = 0; ph < phases; ph++) begin
      foreach (m[i]) begin
        case ($urandom_range(0, 3))
          0: m[i] = $urandom;
          1: m[i] = '0;
          default: m[i] = 32'($signed($urandom_range(0, 4 << FB)) - (2 << FB));
        endcase
      end
      if ($urandom_range(0, 1)) m[15] = ONE;
      load_matrix(m);
      for (int n = 0; n < per_phase; n++)
        send_point(rand_coord(), rand_coord(), rand_coord(), (ph % 3) != 0);
      drain();
    end
  endtask

  // long receiver hold-off so the pipeline fills and stalls its input
  task automatic test_backpressure();
    hold_out = 1'b1;
    fork
      begin
        for (int n = 0; n < 60; n++)
          send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        in_valid <= 1'b0;
        @(negedge clk);
      end
      begin
        repeat (120) @(negedge clk);
        hold_out = 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) mat_shadow[i] = '0;
    mat_shadow[0] = 64'(ONE);
    mat_shadow[2] = {ONE, 32'h0};
    mat_shadow[5] = 64'(ONE);
    mat_shadow[7] = {ONE, 32'h0};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_identity();
    test_special_cases();
    test_backpressure();
    test_random_points(16, 48);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

### sim.f
hw/rtl/hvt_pkg.sv
hw/rtl/hvt_mac.sv
hw/rtl/hvt_div_stage.sv
hw/rtl/homogeneous_vertex_transform_core.sv
verif/homogeneous_vertex_transform_core_tb.sv
